// ----- rtl/hba_pkg.sv -----
package hba_pkg;

   // Tree shape: 64-bit words, three levels (top, middle, leaf).
   localparam int WORD_BITS  = 64;
   localparam int IDX_W      = 6;
   localparam int LEAF_W     = 12;
   localparam int SLOT_W     = 18;
   localparam int LEAF_DEPTH = 4096;
   localparam int MID_DEPTH  = 64;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [1:0] STATUS_FREED     = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic              mode;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] granted_slot;
      logic [1:0]        status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_AL_LEAF,
      ST_SR_MID,
      ST_AL_FOUND,
      ST_RF_MID,
      ST_RF_DESC,
      ST_FR_LEAF,
      ST_FR_MID
   } state_type;

   // Which memory read to launch this cycle.
   typedef enum logic [2:0] {
      RD_NONE,
      RD_LEAF_CUR,
      RD_LEAF_SLOT,
      RD_MID_TOPZ,
      RD_MID_CUR,
      RD_MID_SLOT
   } rd_type;

   // What to do with the read data that is valid this cycle.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_ALLOC,
      ACT_FIND,
      ACT_MARK,
      ACT_REDESC,
      ACT_FREE_LEAF,
      ACT_FREE_MID
   } act_type;

   typedef enum logic [1:0] {
      RSP_NONE,
      RSP_GRANT,
      RSP_FREED,
      RSP_EXH
   } rsp_sel_type;

   typedef struct packed {
      logic        clear_wr;
      logic        take;
      rd_type      rd;
      act_type     act;
      rsp_sel_type rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic exhausted;
      logic top_full;
      logic leaf_full;
      logic leaf_fill;
      logic mid_full;
      logic mid_fill;
      logic top_fill;
   } stat_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
   } lz_type;

   // Lowest clear bit: first the lowest byte with a zero, then the bit in it.
   function automatic lz_type lowest_zero(input word_type w);
      lz_type     r;
      logic [2:0] gi;
      logic [2:0] bi;
      logic [7:0] grp;
      gi = '0;
      bi = '0;
      for (int i = 7; i >= 0; i--) begin
         if (!(&w[i*8 +: 8])) begin
            gi = 3'(i);
         end
      end
      grp = w[gi*8 +: 8];
      for (int j = 7; j >= 0; j--) begin
         if (!grp[j]) begin
            bi = 3'(j);
         end
      end
      r.found = !(&w);
      r.idx   = {gi, bi};
      return r;
   endfunction

   function automatic word_type onehot(input logic [IDX_W-1:0] idx);
      return word_type'(1) << idx;
   endfunction

endpackage

// ----- rtl/hba_ctrl.sv -----
module hba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_mode,
   input  hba_pkg::stat_type  stat,
   output hba_pkg::cmd_type   cmd,
   output logic               busy
);

   hba_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hba_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hba_pkg::ST_CLEAR: begin
            if (stat.clear_done) begin
               state_in = hba_pkg::ST_IDLE;
            end
         end
         hba_pkg::ST_IDLE: begin
            if (start) begin
               if (req_mode == hba_pkg::MODE_FREE) begin
                  state_in = hba_pkg::ST_FR_LEAF;
               end else if (stat.exhausted) begin
                  state_in = stat.top_full ? hba_pkg::ST_IDLE : hba_pkg::ST_SR_MID;
               end else begin
                  state_in = hba_pkg::ST_AL_LEAF;
               end
            end
         end
         hba_pkg::ST_AL_LEAF: begin
            if (stat.leaf_full) begin
               state_in = stat.top_full ? hba_pkg::ST_IDLE : hba_pkg::ST_SR_MID;
            end else begin
               state_in = stat.leaf_fill ? hba_pkg::ST_RF_MID : hba_pkg::ST_IDLE;
            end
         end
         hba_pkg::ST_SR_MID: begin
            state_in = stat.mid_full ? hba_pkg::ST_IDLE : hba_pkg::ST_AL_FOUND;
         end
         hba_pkg::ST_AL_FOUND: begin
            if (!stat.leaf_full && stat.leaf_fill) begin
               state_in = hba_pkg::ST_RF_MID;
            end else begin
               state_in = hba_pkg::ST_IDLE;
            end
         end
         hba_pkg::ST_RF_MID: begin
            if (stat.mid_fill && !stat.top_fill) begin
               state_in = hba_pkg::ST_RF_DESC;
            end else begin
               state_in = hba_pkg::ST_IDLE;
            end
         end
         hba_pkg::ST_RF_DESC: begin
            state_in = hba_pkg::ST_IDLE;
         end
         hba_pkg::ST_FR_LEAF: begin
            state_in = stat.leaf_full ? hba_pkg::ST_FR_MID : hba_pkg::ST_IDLE;
         end
         hba_pkg::ST_FR_MID: begin
            state_in = hba_pkg::ST_IDLE;
         end
         default: begin
            state_in = hba_pkg::ST_CLEAR;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd          = '0;
      cmd.rd       = hba_pkg::RD_NONE;
      cmd.act      = hba_pkg::ACT_NONE;
      cmd.rsp      = hba_pkg::RSP_NONE;
      busy         = 1'b1;
      case (state_ff)
         hba_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         hba_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.take = 1'b1;
               if (req_mode == hba_pkg::MODE_FREE) begin
                  cmd.rd = hba_pkg::RD_LEAF_SLOT;
               end else if (stat.exhausted) begin
                  if (stat.top_full) begin
                     cmd.rsp = hba_pkg::RSP_EXH;
                  end else begin
                     cmd.rd = hba_pkg::RD_MID_TOPZ;
                  end
               end else begin
                  cmd.rd = hba_pkg::RD_LEAF_CUR;
               end
            end
         end
         hba_pkg::ST_AL_LEAF: begin
            if (stat.leaf_full) begin
               if (stat.top_full) begin
                  cmd.rsp = hba_pkg::RSP_EXH;
               end else begin
                  cmd.rd = hba_pkg::RD_MID_TOPZ;
               end
            end else begin
               cmd.act = hba_pkg::ACT_ALLOC;
               if (stat.leaf_fill) begin
                  cmd.rd = hba_pkg::RD_MID_CUR;
               end else begin
                  cmd.rsp = hba_pkg::RSP_GRANT;
               end
            end
         end
         hba_pkg::ST_SR_MID: begin
            if (stat.mid_full) begin
               cmd.rsp = hba_pkg::RSP_EXH;
            end else begin
               cmd.act = hba_pkg::ACT_FIND;
               cmd.rd  = hba_pkg::RD_LEAF_CUR;
            end
         end
         hba_pkg::ST_AL_FOUND: begin
            if (stat.leaf_full) begin
               cmd.rsp = hba_pkg::RSP_EXH;
            end else begin
               cmd.act = hba_pkg::ACT_ALLOC;
               if (stat.leaf_fill) begin
                  cmd.rd = hba_pkg::RD_MID_CUR;
               end else begin
                  cmd.rsp = hba_pkg::RSP_GRANT;
               end
            end
         end
         hba_pkg::ST_RF_MID: begin
            cmd.act = hba_pkg::ACT_MARK;
            if (stat.mid_fill && !stat.top_fill) begin
               cmd.rd = hba_pkg::RD_MID_TOPZ;
            end else begin
               cmd.rsp = hba_pkg::RSP_GRANT;
            end
         end
         hba_pkg::ST_RF_DESC: begin
            cmd.act = hba_pkg::ACT_REDESC;
            cmd.rsp = hba_pkg::RSP_GRANT;
         end
         hba_pkg::ST_FR_LEAF: begin
            cmd.act = hba_pkg::ACT_FREE_LEAF;
            if (stat.leaf_full) begin
               cmd.rd = hba_pkg::RD_MID_SLOT;
            end else begin
               cmd.rsp = hba_pkg::RSP_FREED;
            end
         end
         hba_pkg::ST_FR_MID: begin
            cmd.act = hba_pkg::ACT_FREE_MID;
            cmd.rsp = hba_pkg::RSP_FREED;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ----- rtl/hba_datapath.sv -----
module hba_datapath (
   input  logic              clock,
   input  logic              reset,
   input  hba_pkg::cmd_type  cmd,
   input  hba_pkg::req_type  req_data,
   output hba_pkg::stat_type stat,
   output logic              rsp_strobe,
   output hba_pkg::rsp_type  rsp_data
);

   localparam int IW = hba_pkg::IDX_W;
   localparam int LW = hba_pkg::LEAF_W;
   localparam int SW = hba_pkg::SLOT_W;

   hba_pkg::word_type leaf_mem [hba_pkg::LEAF_DEPTH];
   hba_pkg::word_type mid_mem  [hba_pkg::MID_DEPTH];

   hba_pkg::word_type leaf_rd_ff, mid_rd_ff;
   hba_pkg::word_type top_ff, top_in;
   hba_pkg::req_type  req_ff;
   hba_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic              rsp_strobe_ff;
   logic [LW-1:0]     clr_ff;
   logic [LW-1:0]     cursor_ff, cursor_in;
   logic              flag_ff, flag_in;
   logic [IW-1:0]     mid_addr_ff;
   logic [SW-1:0]     granted_ff, granted_in;

   logic              leaf_we, leaf_re, mid_we, mid_re;
   logic [LW-1:0]     leaf_waddr, leaf_raddr;
   logic [IW-1:0]     mid_waddr, mid_raddr;
   hba_pkg::word_type leaf_wdata, mid_wdata, mid_mark, top_mark;
   hba_pkg::lz_type   lz_leaf, lz_mid, lz_mark, lz_top;

   assign lz_leaf  = hba_pkg::lowest_zero(leaf_rd_ff);
   assign lz_mid   = hba_pkg::lowest_zero(mid_rd_ff);
   assign mid_mark = mid_rd_ff | hba_pkg::onehot(cursor_ff[IW-1:0]);
   assign lz_mark  = hba_pkg::lowest_zero(mid_mark);
   assign top_mark = top_ff | hba_pkg::onehot(cursor_ff[LW-1:IW]);

   always_comb begin
      stat.clear_done = &clr_ff;
      stat.exhausted  = flag_ff;
      stat.top_full   = &top_ff;
      stat.leaf_full  = &leaf_rd_ff;
      stat.leaf_fill  = &(leaf_rd_ff | hba_pkg::onehot(lz_leaf.idx));
      stat.mid_full   = &mid_rd_ff;
      stat.mid_fill   = &mid_mark;
      stat.top_fill   = &top_mark;
   end

   // Next values of the tree top, cursor, exhausted flag and granted slot.
   always_comb begin
      top_in     = top_ff;
      cursor_in  = cursor_ff;
      flag_in    = flag_ff;
      granted_in = granted_ff;
      case (cmd.act)
         hba_pkg::ACT_ALLOC: begin
            granted_in = {cursor_ff, lz_leaf.idx};
         end
         hba_pkg::ACT_FIND: begin
            cursor_in = {mid_addr_ff, lz_mid.idx};
            flag_in   = 1'b0;
         end
         hba_pkg::ACT_MARK: begin
            if (&mid_mark) begin
               top_in = top_mark;
               if (&top_mark) begin
                  flag_in = 1'b1;
               end
            end else begin
               cursor_in = {cursor_ff[LW-1:IW], lz_mark.idx};
            end
         end
         hba_pkg::ACT_REDESC: begin
            if (&mid_rd_ff) begin
               flag_in = 1'b1;
            end else begin
               cursor_in = {mid_addr_ff, lz_mid.idx};
            end
         end
         hba_pkg::ACT_FREE_MID: begin
            if (&mid_rd_ff) begin
               top_in = top_ff & ~hba_pkg::onehot(req_ff.slot_index[SW-1:LW]);
            end
         end
         default: begin
            top_in = top_ff;
         end
      endcase
      if (cmd.rsp == hba_pkg::RSP_EXH) begin
         flag_in = 1'b1;
      end
   end

   assign lz_top = hba_pkg::lowest_zero(top_in);

   // Memory write and read ports.
   always_comb begin
      leaf_we    = 1'b0;
      leaf_waddr = cursor_ff;
      leaf_wdata = leaf_rd_ff | hba_pkg::onehot(lz_leaf.idx);
      mid_we     = 1'b0;
      mid_waddr  = cursor_ff[LW-1:IW];
      mid_wdata  = mid_mark;
      case (cmd.act)
         hba_pkg::ACT_ALLOC: begin
            leaf_we = 1'b1;
         end
         hba_pkg::ACT_FREE_LEAF: begin
            leaf_we    = 1'b1;
            leaf_waddr = req_ff.slot_index[SW-1:IW];
            leaf_wdata = leaf_rd_ff & ~hba_pkg::onehot(req_ff.slot_index[IW-1:0]);
         end
         hba_pkg::ACT_MARK: begin
            mid_we = 1'b1;
         end
         hba_pkg::ACT_FREE_MID: begin
            mid_we    = 1'b1;
            mid_waddr = req_ff.slot_index[SW-1:LW];
            mid_wdata = mid_rd_ff & ~hba_pkg::onehot(req_ff.slot_index[LW-1:IW]);
         end
         default: begin
            leaf_we = 1'b0;
         end
      endcase
      // The clearing pass after reset owns both write ports.
      if (cmd.clear_wr) begin
         leaf_we    = 1'b1;
         leaf_waddr = clr_ff;
         leaf_wdata = '0;
         mid_we     = 1'b1;
         mid_waddr  = clr_ff[IW-1:0];
         mid_wdata  = '0;
      end
   end

   always_comb begin
      leaf_re    = 1'b0;
      leaf_raddr = cursor_in;
      mid_re     = 1'b0;
      mid_raddr  = lz_top.idx;
      case (cmd.rd)
         hba_pkg::RD_LEAF_CUR: begin
            leaf_re = 1'b1;
         end
         hba_pkg::RD_LEAF_SLOT: begin
            leaf_re    = 1'b1;
            leaf_raddr = req_data.slot_index[SW-1:IW];
         end
         hba_pkg::RD_MID_TOPZ: begin
            mid_re = 1'b1;
         end
         hba_pkg::RD_MID_CUR: begin
            mid_re    = 1'b1;
            mid_raddr = cursor_ff[LW-1:IW];
         end
         hba_pkg::RD_MID_SLOT: begin
            mid_re    = 1'b1;
            mid_raddr = req_ff.slot_index[SW-1:LW];
         end
         default: begin
            leaf_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem[leaf_waddr] <= leaf_wdata;
      end
      if (leaf_re) begin
         leaf_rd_ff <= leaf_mem[leaf_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (mid_we) begin
         mid_mem[mid_waddr] <= mid_wdata;
      end
      if (mid_re) begin
         mid_rd_ff   <= mid_mem[mid_raddr];
         mid_addr_ff <= mid_raddr;
      end
   end

   always_comb begin
      rsp_data_in.granted_slot = '0;
      rsp_data_in.status       = hba_pkg::STATUS_FREED;
      case (cmd.rsp)
         hba_pkg::RSP_GRANT: begin
            rsp_data_in.granted_slot = granted_in;
            rsp_data_in.status       = hba_pkg::STATUS_ALLOCATED;
         end
         hba_pkg::RSP_EXH: begin
            rsp_data_in.status = hba_pkg::STATUS_EXHAUSTED;
         end
         default: begin
            rsp_data_in.status = hba_pkg::STATUS_FREED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         top_ff        <= '0;
         cursor_ff     <= '0;
         flag_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.clear_wr) begin
            clr_ff <= clr_ff + 1'b1;
         end
         top_ff        <= top_in;
         cursor_ff     <= cursor_in;
         flag_ff       <= flag_in;
         rsp_strobe_ff <= (cmd.rsp != hba_pkg::RSP_NONE);
      end
   end

   always_ff @(posedge clock) begin
      granted_ff <= granted_in;
      if (cmd.take) begin
         req_ff <= req_data;
      end
      if (cmd.rsp != hba_pkg::RSP_NONE) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- rtl/hierarchical_bitmap_allocator.sv -----
// Channel   Ports                        Direction  Word
// request   start, busy, req_data        in         mode, slot_index
// response  rsp_strobe, rsp_data         out        granted_slot, status
//
// A request word is taken at a rising edge with start high and busy low. Its
// response word is on rsp_data for one cycle under rsp_strobe, with busy low
// again, and the receiver cannot stall it. After reset a clearing pass zeroes
// both memories, one leaf word a cycle, with busy high.
// An allocate takes a slot from the cursor leaf; when that leaf fills, the
// marks climb. After exhaustion, or on a full cursor leaf without the flag,
// which the marks keep from arising, the cursor is searched again from the
// top, and a full tree with the flag set is answered without a memory read.
// A free clears the slot bit, and the marks above it when a full leaf reopens.
// Each step waits on one registered read of the leaf or middle memory.

module hierarchical_bitmap_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hba_pkg::req_type req_data,
   output logic             rsp_strobe,
   output hba_pkg::rsp_type rsp_data
);

   // The controller sequences the walk up and down the tree; the datapath
   // owns the occupancy memories, the top word, the cursor and the flag.
   hba_pkg::cmd_type  cmd;
   hba_pkg::stat_type stat;

   hba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_data.mode),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   hba_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- sim/tb_hierarchical_bitmap_allocator.sv -----
`timescale 1ns / 1ps

module tb_hierarchical_bitmap_allocator;

   localparam int WORD_BITS  = hba_pkg::WORD_BITS;
   localparam int LEAF_W     = hba_pkg::LEAF_W;
   localparam int SLOT_W     = hba_pkg::SLOT_W;
   localparam int LEAF_DEPTH = hba_pkg::LEAF_DEPTH;
   localparam int MID_DEPTH  = hba_pkg::MID_DEPTH;

   // Clock, reset and the request/response channels of the allocator.
   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   hba_pkg::req_type req_data;
   logic             rsp_strobe;
   hba_pkg::rsp_type rsp_data;

   hierarchical_bitmap_allocator DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the occupancy tree. A leaf bit is one slot; a middle or
   // top bit is set exactly when the child word below it is full.
   hba_pkg::word_type occ_leaf [LEAF_DEPTH];
   hba_pkg::word_type occ_mid  [MID_DEPTH];
   hba_pkg::word_type occ_top;
   logic [LEAF_W-1:0] shadow_cursor;
   logic              shadow_exhausted;

   // Responses predicted for accepted request words, oldest first.
   hba_pkg::rsp_type  expected_rsp [$];
   // Slots believed to be held, used to build well-formed free requests.
   logic [SLOT_W-1:0] held_slots [$];

   // When set, the sender inserts random gaps between request words.
   logic idle_on;
   int   error_count;

   // Index of the lowest clear bit in a word, or -1 when the word is full.
   function automatic int first_clear(input hba_pkg::word_type w);
      for (int b = 0; b < WORD_BITS; b++) begin
         if (!w[b]) begin
            return b;
         end
      end
      return -1;
   endfunction

   // Walk down from the top word (level 0) or from middle word idx
   // (level 1) to the lowest leaf that still has a free slot.
   function automatic logic descend_to_leaf(input int lvl, input int idx, output int leaf);
      int b;
      leaf = 0;
      if (lvl == 0) begin
         b = first_clear(occ_top);
         if (b < 0) begin
            return 1'b0;
         end
         idx = b;
      end
      b = first_clear(occ_mid[idx]);
      if (b < 0) begin
         return 1'b0;
      end
      leaf = idx * WORD_BITS + b;
      return 1'b1;
   endfunction

   // A leaf has just filled: set the full marks upward until a word still
   // has room, then move the cursor to the lowest open leaf below it.
   function automatic void mark_leaf_full(input int leaf);
      int parent;
      int found;
      parent = leaf / WORD_BITS;
      occ_mid[parent][leaf % WORD_BITS] = 1'b1;
      if (occ_mid[parent] != '1) begin
         if (descend_to_leaf(1, parent, found)) begin
            shadow_cursor = LEAF_W'(found);
         end else begin
            shadow_exhausted = 1'b1;
         end
         return;
      end
      occ_top[parent] = 1'b1;
      if (occ_top != '1 && descend_to_leaf(0, 0, found)) begin
         shadow_cursor = LEAF_W'(found);
      end else begin
         shadow_exhausted = 1'b1;
      end
   endfunction

   // Clear a slot bit; the full mark one level up is cleared only when the
   // word just changed had been full, and so on toward the top.
   function automatic void release_slot(input logic [SLOT_W-1:0] slot);
      int                leaf;
      int                mid;
      hba_pkg::word_type old;
      leaf = int'(slot) / WORD_BITS;
      old = occ_leaf[leaf];
      occ_leaf[leaf][int'(slot) % WORD_BITS] = 1'b0;
      if (old != '1) begin
         return;
      end
      mid = leaf / WORD_BITS;
      old = occ_mid[mid];
      occ_mid[mid][leaf % WORD_BITS] = 1'b0;
      if (old != '1) begin
         return;
      end
      occ_top[mid] = 1'b0;
   endfunction

   // Apply one request word to the shadow tree and return its response.
   function automatic hba_pkg::rsp_type allocator_response(input hba_pkg::req_type w);
      hba_pkg::rsp_type r;
      int               leaf;
      int               b;
      r.granted_slot = '0;
      if (w.mode == hba_pkg::MODE_FREE) begin
         release_slot(w.slot_index);
         r.status = hba_pkg::STATUS_FREED;
         return r;
      end
      // After exhaustion the cursor is stale, so search again from the top.
      if (shadow_exhausted || occ_leaf[shadow_cursor] == '1) begin
         if (!descend_to_leaf(0, 0, leaf)) begin
            shadow_exhausted = 1'b1;
            r.status = hba_pkg::STATUS_EXHAUSTED;
            return r;
         end
         shadow_cursor = LEAF_W'(leaf);
         shadow_exhausted = 1'b0;
      end
      b = first_clear(occ_leaf[shadow_cursor]);
      if (b < 0) begin
         shadow_exhausted = 1'b1;
         r.status = hba_pkg::STATUS_EXHAUSTED;
         return r;
      end
      occ_leaf[shadow_cursor][b] = 1'b1;
      r.granted_slot = SLOT_W'(int'(shadow_cursor) * WORD_BITS + b);
      r.status = hba_pkg::STATUS_ALLOCATED;
      if (occ_leaf[shadow_cursor] == '1) begin
         mark_leaf_full(int'(shadow_cursor));
      end
      return r;
   endfunction

   // Present one request word and hold it until the allocator takes it. Start
   // is only lowered when a gap is inserted, so back-to-back words keep it
   // high without a second assignment in the acceptance time step.
   task automatic send_word(input logic mode, input logic [SLOT_W-1:0] slot);
      hba_pkg::req_type w;
      hba_pkg::rsp_type r;
      w.mode = mode;
      w.slot_index = slot;
      if (idle_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      r = allocator_response(w);
      if (r.status == hba_pkg::STATUS_ALLOCATED) begin
         held_slots.push_back(r.granted_slot);
      end
      expected_rsp.push_back(r);
   endtask

   // Hold the sender off until every outstanding response has arrived.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   // Pick a held slot at random and drop it from the held list.
   function automatic logic [SLOT_W-1:0] take_held_slot();
      int                i;
      logic [SLOT_W-1:0] slot;
      i = $urandom_range(0, held_slots.size() - 1);
      slot = held_slots[i];
      held_slots[i] = held_slots[held_slots.size() - 1];
      held_slots.pop_back();
      return slot;
   endfunction

   // Response checker. The strobe and data are sampled at the edge that
   // ends the strobe cycle, before the allocator updates them.
   hba_pkg::rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            error_count++;
            $display("%0t: response with none expected, got slot %0d status %0d",
                     $time, rsp_data.granted_slot, rsp_data.status);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.granted_slot !== want.granted_slot) begin
               error_count++;
               $display("%0t: granted_slot expected %0d actual %0d",
                        $time, want.granted_slot, rsp_data.granted_slot);
            end
            if (rsp_data.status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
            end
         end
      end
   end

   // Short directed sequence: first grants, reuse of a freed slot, a double
   // free, and the extremes of slot_index on both kinds of request.
   task automatic test_directed_cases();
      repeat (3) send_word(hba_pkg::MODE_ALLOC, '0);
      send_word(hba_pkg::MODE_FREE, SLOT_W'(1));
      send_word(hba_pkg::MODE_ALLOC, '0);
      send_word(hba_pkg::MODE_FREE, SLOT_W'(1));
      // Freeing a slot that is already free still answers freed.
      send_word(hba_pkg::MODE_FREE, SLOT_W'(1));
      send_word(hba_pkg::MODE_FREE, '1);
      send_word(hba_pkg::MODE_FREE, '0);
      // The slot field is ignored on allocate.
      send_word(hba_pkg::MODE_ALLOC, '1);
      send_word(hba_pkg::MODE_ALLOC, '0);
      send_word(hba_pkg::MODE_ALLOC, SLOT_W'(18'h2AAAA));
   endtask

   // Random traffic biased toward allocation so that leaves fill and the
   // marks climb, mixed with frees of held slots (which reopen full leaves)
   // and frees of arbitrary slot numbers as noise.
   task automatic test_random_traffic(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60 || (pick < 88 && held_slots.size() == 0)) begin
            send_word(hba_pkg::MODE_ALLOC, SLOT_W'($urandom));
         end else if (pick < 88) begin
            send_word(hba_pkg::MODE_FREE, take_held_slot());
         end else begin
            send_word(hba_pkg::MODE_FREE, SLOT_W'($urandom_range(0, 262143)));
         end
         if ($urandom_range(0, 299) == 0) begin
            wait_drained();
         end
      end
   endtask

   // Closing stretch without gaps: frees and allocates back to back.
   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 1) == 0 && held_slots.size() != 0) begin
            send_word(hba_pkg::MODE_FREE, take_held_slot());
         end else begin
            send_word(hba_pkg::MODE_ALLOC, SLOT_W'($urandom));
         end
      end
   endtask

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      foreach (occ_leaf[i]) begin
         occ_leaf[i] = '0;
      end
      foreach (occ_mid[i]) begin
         occ_mid[i] = '0;
      end
      occ_top = '0;
      shadow_cursor = '0;
      shadow_exhausted = 1'b0;
      error_count = 0;
      idle_on = 1'b1;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The clearing pass after reset holds busy high; the first send simply
      // waits for it through the handshake.
      test_directed_cases();
      test_random_traffic(1290);
      wait_drained();
      test_back_to_back(150);

      start <= 1'b0;
      for (int n = 0; n < 1000 && expected_rsp.size() != 0; n++) begin
         @(posedge clock);
      end
      // Keep clocking so that a stray extra strobe would still be seen.
      repeat (8) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected responses never arrived", $time, expected_rsp.size());
      end
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- hierarchical_bitmap_allocator.f -----
rtl/hba_pkg.sv
rtl/hba_ctrl.sv
rtl/hba_datapath.sv
rtl/hierarchical_bitmap_allocator.sv
sim/tb_hierarchical_bitmap_allocator.sv
